[design/rpp_pkg.sv]
// ============================================================================
// rpp_pkg : shared types and constants for the pivot rotator
// Coordinate widths, fixed-point format, arctangent table and register codes.
// ============================================================================
package rpp_pkg;

    // Coordinate and angle formats
    localparam int COORD_WIDTH  = 16;
    localparam int ANGLE_W      = 16;
    localparam int CFG_DATA_W   = (COORD_WIDTH > ANGLE_W) ? COORD_WIDTH : ANGLE_W;
    localparam int DIFF_W       = COORD_WIDTH + 1;      // point minus pivot
    localparam int FRAC_BITS    = 28;
    localparam int KQ_W         = 28;                   // magnitude bits of gain
    localparam int PROD_W       = DIFF_W + KQ_W + 1;
    localparam int VEC_W        = PROD_W + 2;           // headroom for CORDIC growth
    localparam int Z_W          = 32;                   // 2^-32 turn units
    localparam int SHIFT_W      = VEC_W - FRAC_BITS;    // rounded integer part
    localparam int SUM_W        = SHIFT_W + 1;          // plus pivot

    // Micro-rotation stage count
    localparam int ANGLE_STAGES  = 16;
    localparam int MAX_STAGES    = 24;
    localparam int CORDIC_STAGES = (ANGLE_STAGES > MAX_STAGES) ? MAX_STAGES : ANGLE_STAGES;

    // Gain compensation, round(0.60725293500888 * 2^28)
    localparam logic signed [KQ_W:0] KQ = 29'sd163008219;

    // Quarter-turn rounding offset in binary angle units
    localparam logic [ANGLE_W-1:0] QUAD_HALF = 16'h2000;

    // atan(2^-i) scaled to 2^32 per turn
    localparam logic signed [Z_W-1:0] ATAN_TURNS [MAX_STAGES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PIVOT_X = 2'd0,
        REG_PIVOT_Y = 2'd1,
        REG_ANGLE   = 2'd2
    } reg_idx_t;

    // Quarter-turn pre-rotation
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    // Vector travelling through the CORDIC stages
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [Z_W-1:0]   z;
    } rpp_vec_t;

endpackage

[design/rpp_intf.sv]
// ============================================================================
// rpp_intf : stream and configuration interfaces of the pivot rotator
// Valid/ready channels for vertices, rotated results and register writes.
// ============================================================================
interface rpp_vertex_if;
    import rpp_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface rpp_result_if;
    import rpp_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic                          saturated;

    modport source (output valid, output rotated_x, output rotated_y, output saturated,
                    input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, input saturated,
                    output ready);
endinterface

interface rpp_cfg_if;
    import rpp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[design/rpp_cordic.sv]
// ============================================================================
// rpp_cordic : pipelined CORDIC rotator
// One micro-rotation per register stage, each stage with its own valid bit.
// ============================================================================
module rpp_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rpp_pkg::rpp_vec_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rpp_pkg::rpp_vec_t out_data
);
    import rpp_pkg::*;

    logic                   valid_reg   [CORDIC_STAGES];
    rpp_vec_t               vec_reg     [CORDIC_STAGES];
    logic [CORDIC_STAGES:0] stage_ready;

    assign stage_ready[CORDIC_STAGES] = out_ready;
    assign in_ready                   = stage_ready[0];
    assign out_valid                  = valid_reg[CORDIC_STAGES-1];
    assign out_data                   = vec_reg[CORDIC_STAGES-1];

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_stage
        rpp_vec_t                src;
        logic                    src_valid;
        logic signed [VEC_W-1:0] sx;
        logic signed [VEC_W-1:0] sy;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        logic signed [Z_W-1:0]   sz;
        rpp_vec_t                vec_next;

        if (k == 0)
        begin : g_first
            assign src       = in_data;
            assign src_valid = in_valid;
        end
        else
        begin : g_rest
            assign src       = vec_reg[k-1];
            assign src_valid = valid_reg[k-1];
        end

        assign sx = src.x;
        assign sy = src.y;
        assign sz = src.z;
        assign xs = sx >>> k;
        assign ys = sy >>> k;

        // Steer towards zero residual angle
        always_comb
        begin
            if (!sz[Z_W-1])
            begin
                vec_next.x = sx - ys;
                vec_next.y = sy + xs;
                vec_next.z = sz - ATAN_TURNS[k];
            end
            else
            begin
                vec_next.x = sx + ys;
                vec_next.y = sy - xs;
                vec_next.z = sz + ATAN_TURNS[k];
            end
        end

        assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (stage_ready[k])
                valid_reg[k] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[k] && src_valid)
                vec_reg[k] <= vec_next;
        end
    end

endmodule

[design/rotate_point_about_pivot.sv]
// ============================================================================
// rotate_point_about_pivot : rotate vertices about a configured pivot
// Quarter-turn pre-rotation, gain scaling, pipelined CORDIC, rounding and
// saturation to the coordinate range.
// ============================================================================
//
//  Channel  Role   Transfer carries
//  -------  -----  ---------------------------------------------
//  vertex   sink   point_x, point_y
//  result   source rotated_x, rotated_y, saturated
//  cfg      sink   reg_index (0 pivot_x, 1 pivot_y, 2 angle), wdata
//
//  One vertex per cycle is taken while the entry stage has room; each
//  passes the entry and multiply registers, the one-stage-per-iteration
//  CORDIC chain, then the rounding and clipping registers.
//  Reset clears the pivot and angle to zero and empties every stage.
//  Each stage holds its item while the stage after it is full, so a stall
//  on result backs up one stage at a time and bubbles are squeezed out.
//  The cfg channel is always ready; write it only while the block is empty.
//
module rotate_point_about_pivot (
    input  logic clk,
    input  logic rst_n,
    rpp_vertex_if.sink   vertex,
    rpp_result_if.source result,
    rpp_cfg_if.sink      cfg
);
    import rpp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] pivot_x_reg;
    logic signed [COORD_WIDTH-1:0] pivot_y_reg;
    logic        [ANGLE_W-1:0]     angle_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            angle_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.reg_index))
                REG_PIVOT_X: pivot_x_reg <= cfg.wdata[COORD_WIDTH-1:0];
                REG_PIVOT_Y: pivot_y_reg <= cfg.wdata[COORD_WIDTH-1:0];
                REG_ANGLE:   angle_reg   <= cfg.wdata[ANGLE_W-1:0];
                default:     ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: offset from pivot, quadrant and residual angle
    // ------------------------------------------------------------------
    logic                     s0_valid_reg;
    logic                     s0_ready;
    logic signed [DIFF_W-1:0] s0_dx_reg;
    logic signed [DIFF_W-1:0] s0_dy_reg;
    quad_t                    s0_quad_reg;
    logic signed [Z_W-1:0]    s0_z_reg;

    logic signed [DIFF_W-1:0] s0_dx_next;
    logic signed [DIFF_W-1:0] s0_dy_next;
    logic [ANGLE_W-1:0]       angle_biased;
    quad_t                    s0_quad_next;
    logic [ANGLE_W-1:0]       residual;
    logic signed [Z_W-1:0]    s0_z_next;

    assign s0_dx_next   = DIFF_W'(vertex.point_x) - DIFF_W'(pivot_x_reg);
    assign s0_dy_next   = DIFF_W'(vertex.point_y) - DIFF_W'(pivot_y_reg);
    assign angle_biased = angle_reg + QUAD_HALF;
    assign s0_quad_next = quad_t'(angle_biased[ANGLE_W-1 -: 2]);
    // Residual lies in one eighth turn either side; scale to 2^-32 turn
    assign residual     = angle_reg - {s0_quad_next, {(ANGLE_W-2){1'b0}}};
    assign s0_z_next    = {residual, {(Z_W-ANGLE_W){1'b0}}};

    assign vertex.ready = s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s0_ready)
            s0_valid_reg <= vertex.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && vertex.valid)
        begin
            s0_dx_reg   <= s0_dx_next;
            s0_dy_reg   <= s0_dy_next;
            s0_quad_reg <= s0_quad_next;
            s0_z_reg    <= s0_z_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: quarter-turn swap and gain compensation multiply
    // ------------------------------------------------------------------
    logic                     s1_valid_reg;
    logic                     s1_ready;
    rpp_vec_t                 s1_vec_reg;
    rpp_vec_t                 s1_vec_next;
    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] vy;
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;

    always_comb
    begin
        case (s0_quad_reg)
            QUAD_0:
            begin
                vx = s0_dx_reg;
                vy = s0_dy_reg;
            end
            QUAD_90:
            begin
                vx = -s0_dy_reg;
                vy = s0_dx_reg;
            end
            QUAD_180:
            begin
                vx = -s0_dx_reg;
                vy = -s0_dy_reg;
            end
            QUAD_270:
            begin
                vx = s0_dy_reg;
                vy = -s0_dx_reg;
            end
            default:
            begin
                vx = s0_dx_reg;
                vy = s0_dy_reg;
            end
        endcase
    end

    assign px = PROD_W'(vx) * PROD_W'(KQ);
    assign py = PROD_W'(vy) * PROD_W'(KQ);

    assign s1_vec_next.x = VEC_W'(px);
    assign s1_vec_next.y = VEC_W'(py);
    assign s1_vec_next.z = s0_z_reg;

    assign s0_ready = !s0_valid_reg || s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_valid_reg)
            s1_vec_reg <= s1_vec_next;
    end

    // ------------------------------------------------------------------
    // CORDIC micro-rotations
    // ------------------------------------------------------------------
    logic     cord_in_ready;
    logic     cord_valid;
    logic     cord_ready;
    rpp_vec_t cord_vec;

    assign s1_ready = !s1_valid_reg || cord_in_ready;

    rpp_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (cord_in_ready),
        .in_data   (s1_vec_reg),
        .out_valid (cord_valid),
        .out_ready (cord_ready),
        .out_data  (cord_vec)
    );

    // ------------------------------------------------------------------
    // Stage 2: round to nearest and add pivot back
    // ------------------------------------------------------------------
    logic                      s2_valid_reg;
    logic                      s2_ready;
    logic signed [SUM_W-1:0]   s2_rx_reg;
    logic signed [SUM_W-1:0]   s2_ry_reg;
    logic signed [SUM_W-1:0]   s2_rx_next;
    logic signed [SUM_W-1:0]   s2_ry_next;
    logic signed [VEC_W-1:0]   xr;
    logic signed [VEC_W-1:0]   yr;
    logic signed [SHIFT_W-1:0] xi;
    logic signed [SHIFT_W-1:0] yi;

    localparam logic signed [VEC_W-1:0] ROUND_HALF = VEC_W'(1) <<< (FRAC_BITS - 1);

    assign xr = cord_vec.x + ROUND_HALF;
    assign yr = cord_vec.y + ROUND_HALF;
    assign xi = xr[VEC_W-1:FRAC_BITS];
    assign yi = yr[VEC_W-1:FRAC_BITS];

    assign s2_rx_next = SUM_W'(xi) + SUM_W'(pivot_x_reg);
    assign s2_ry_next = SUM_W'(yi) + SUM_W'(pivot_y_reg);

    assign cord_ready = !cord_valid || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= cord_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && cord_valid)
        begin
            s2_rx_reg <= s2_rx_next;
            s2_ry_reg <= s2_ry_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: clip to the coordinate range, output register
    // ------------------------------------------------------------------
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic                          s3_valid_reg;
    logic                          s3_ready;
    logic signed [COORD_WIDTH-1:0] s3_rx_reg;
    logic signed [COORD_WIDTH-1:0] s3_ry_reg;
    logic                          s3_sat_reg;
    logic signed [COORD_WIDTH-1:0] s3_rx_next;
    logic signed [COORD_WIDTH-1:0] s3_ry_next;
    logic                          s3_sat_next;
    logic                          x_hi;
    logic                          x_lo;
    logic                          y_hi;
    logic                          y_lo;

    assign x_hi = s2_rx_reg > SUM_W'(COORD_MAX);
    assign x_lo = s2_rx_reg < SUM_W'(COORD_MIN);
    assign y_hi = s2_ry_reg > SUM_W'(COORD_MAX);
    assign y_lo = s2_ry_reg < SUM_W'(COORD_MIN);

    assign s3_rx_next  = x_hi ? COORD_MAX : (x_lo ? COORD_MIN : s2_rx_reg[COORD_WIDTH-1:0]);
    assign s3_ry_next  = y_hi ? COORD_MAX : (y_lo ? COORD_MIN : s2_ry_reg[COORD_WIDTH-1:0]);
    assign s3_sat_next = x_hi || x_lo || y_hi || y_lo;

    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s3_ready = !s3_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_ready)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_rx_reg  <= s3_rx_next;
            s3_ry_reg  <= s3_ry_next;
            s3_sat_reg <= s3_sat_next;
        end
    end

    assign result.valid     = s3_valid_reg;
    assign result.rotated_x = s3_rx_reg;
    assign result.rotated_y = s3_ry_reg;
    assign result.saturated = s3_sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A vertex transfer always lands in the entry stage
    a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid && vertex.ready |=> s0_valid_reg)
        else $error("accepted vertex did not enter stage 0");

    // Back-pressure at the input only when the entry stage is full and blocked
    a_entry_block: assert property (@(posedge clk) disable iff (!rst_n)
        !vertex.ready |-> s0_valid_reg && !s1_ready)
        else $error("vertex refused with room in stage 0");

    // A flagged result has at least one coordinate on a bound
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            result.rotated_x == COORD_MAX || result.rotated_x == COORD_MIN ||
            result.rotated_y == COORD_MAX || result.rotated_y == COORD_MIN)
        else $error("saturated flag set with both coordinates inside the range");

endmodule

[test/tb_rotate_point_about_pivot.sv]
// ----------------------------------------------------------------------------
// tb_rotate_point_about_pivot : self-checking bench for the pivot rotator
// Streams vertices through the block under a range of pivot and angle
// settings, predicts each rotated vertex with an independent fixed-point
// CORDIC model or by hand and checks every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_rotate_point_about_pivot;
    timeunit 1ns;
    timeprecision 1ps;

    import rpp_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t rotated_x;
        coord_t rotated_y;
        logic   saturated;
    } rotation_t;

    // One directed probe: the setting to apply, the vertex and, where it is
    // obvious, the rotated vertex typed in by hand
    typedef struct packed {
        coord_t             piv_x;
        coord_t             piv_y;
        logic [ANGLE_W-1:0] ang;
        coord_t             px;
        coord_t             py;
        bit                 typed;
        rotation_t          want;
    } probe_t;

    localparam coord_t C_MAX = coord_t'((1 << (COORD_WIDTH - 1)) - 1);
    localparam coord_t C_MIN = coord_t'(-(1 << (COORD_WIDTH - 1)));

    // Register index that decodes to nothing
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int    PIPE_LATENCY   = CORDIC_STAGES + 4;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    HOLD_OFF_LEN   = 250;
    localparam int    IDLE_PERCENT   = 12;
    localparam int    RANDOM_PHASES  = 12;
    localparam longint GAIN_COMP     = 163008219;   // CORDIC gain compensation, 2^28 scaled
    localparam int    ROUND_SHIFT    = 28;

    // atan(2^-i) in 2^-32 turn units
    localparam longint ARCTAN_TURNS [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    localparam int N_PROBES = 20;
    localparam probe_t DIRECTED_PROBES [N_PROBES] = '{
        // reset setting: the origin must stay exactly where it is
        '{0, 0, 16'h0000, 0, 0, 1'b1, '{0, 0, 1'b0}},
        '{0, 0, 16'h0000, C_MAX, C_MAX, 1'b0, '0},
        '{0, 0, 16'h0000, C_MIN, C_MIN, 1'b0, '0},
        '{0, 0, 16'h0000, C_MAX, C_MIN, 1'b0, '0},
        // every quarter turn
        '{0, 0, 16'h4000, 1000, 0, 1'b0, '0},
        '{0, 0, 16'h8000, 1000, 2000, 1'b0, '0},
        '{0, 0, 16'hC000, 1000, 2000, 1'b0, '0},
        // quadrant boundaries: largest positive and negative residual
        '{0, 0, 16'h1FFF, 20000, -5000, 1'b0, '0},
        '{0, 0, 16'h2000, C_MAX, C_MAX, 1'b0, '0},
        '{0, 0, 16'hFFFF, -30000, 12345, 1'b0, '0},
        '{0, 0, 16'hE000, -1, 1, 1'b0, '0},
        '{0, 0, 16'h6000, 123, -4567, 1'b0, '0},
        '{0, 0, 16'hA000, -32000, -32000, 1'b0, '0},
        // half turn about a corner pivot: both coordinates clip
        '{C_MAX, C_MAX, 16'h8000, C_MIN, C_MIN, 1'b1, '{C_MAX, C_MAX, 1'b1}},
        '{C_MIN, C_MIN, 16'h8000, C_MAX, C_MAX, 1'b1, '{C_MIN, C_MIN, 1'b1}},
        // vertex on the pivot comes back unchanged at any angle, then mixed cases
        '{C_MAX, C_MIN, 16'h1234, C_MAX, C_MIN, 1'b1, '{C_MAX, C_MIN, 1'b0}},
        '{C_MIN, C_MAX, 16'h2AAA, 0, 0, 1'b0, '0},
        '{100, -200, 16'h0001, C_MIN, C_MAX, 1'b0, '0},
        '{1, 1, 16'h0000, 1, 1, 1'b1, '{1, 1, 1'b0}},
        '{-1, -1, 16'h7FFF, -1, 0, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    rpp_vertex_if vertex_ch ();
    rpp_result_if result_ch ();
    rpp_cfg_if    cfg_ch ();

    rotate_point_about_pivot dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Local copy of the register file, updated on every accepted write
    coord_t             model_px    = '0;
    coord_t             model_py    = '0;
    logic [ANGLE_W-1:0] model_angle = '0;

    // Rotated vertices still owed by the block, oldest first
    rotation_t pending_rotations [$];

    // Shared control between the sender, receiver and checker
    bit calm            = 1'b0;     // no idling on either side
    int hold_off_cycles = 0;        // receiver stall length still to serve
    int failures        = 0;
    int vertices_sent   = 0;
    int results_seen    = 0;
    int clipped_seen    = 0;
    int settings_used   = 0;
    int idle_cycles     = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: quarter-turn pre-rotation, gain scaling, micro-rotations,
    // rounding to nearest and clipping, all on 64-bit integers
    // ------------------------------------------------------------------------
    function automatic rotation_t rotate_about_pivot(input coord_t x, input coord_t y);
        longint         dx, dy, vx, vy, acc_x, acc_y, z, sx, sy, rx, ry;
        longint         hi, lo;
        logic [16:0]    ang_sum;
        logic [15:0]    resid;
        quad_t          quad;
        rotation_t      res;
        int             i;

        dx = longint'(x) - longint'(model_px);
        dy = longint'(y) - longint'(model_py);

        // Round the angle to the nearest quarter turn; keep the signed rest
        ang_sum = {1'b0, model_angle} + 17'h2000;
        quad    = quad_t'(ang_sum[15:14]);
        resid   = model_angle - {quad, 14'b0};
        z       = longint'($signed(resid)) * 65536;

        case (quad)
            QUAD_0:   begin vx = dx;  vy = dy;  end
            QUAD_90:  begin vx = -dy; vy = dx;  end
            QUAD_180: begin vx = -dx; vy = -dy; end
            default:  begin vx = dy;  vy = -dx; end
        endcase

        acc_x = vx * GAIN_COMP;
        acc_y = vy * GAIN_COMP;
        for (i = 0; i < CORDIC_STAGES; i++)
        begin
            sx = acc_x >>> i;
            sy = acc_y >>> i;
            if (z >= 0)
            begin
                acc_x = acc_x - sy;
                acc_y = acc_y + sx;
                z     = z - ARCTAN_TURNS[i];
            end
            else
            begin
                acc_x = acc_x + sy;
                acc_y = acc_y - sx;
                z     = z + ARCTAN_TURNS[i];
            end
        end

        rx = ((acc_x + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT) + longint'(model_px);
        ry = ((acc_y + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT) + longint'(model_py);

        hi = longint'(C_MAX);
        lo = longint'(C_MIN);
        res.saturated = 1'b0;
        if (rx > hi)
        begin
            rx = hi;
            res.saturated = 1'b1;
        end
        else if (rx < lo)
        begin
            rx = lo;
            res.saturated = 1'b1;
        end
        if (ry > hi)
        begin
            ry = hi;
            res.saturated = 1'b1;
        end
        else if (ry < lo)
        begin
            ry = lo;
            res.saturated = 1'b1;
        end
        res.rotated_x = coord_t'(rx);
        res.rotated_y = coord_t'(ry);
        return res;
    endfunction

    // Full-range, near-centre and near-zero values, and the two extremes
    function automatic coord_t random_coord(input coord_t centre);
        int pick;

        pick = $urandom_range(19);
        if (pick < 11)
            return coord_t'($urandom);
        else if (pick < 16)
            return coord_t'(centre + coord_t'($urandom_range(1023)) - coord_t'(512));
        else if (pick < 18)
            return coord_t'($urandom_range(255)) - coord_t'(128);
        else if (pick == 18)
            return C_MAX;
        else
            return C_MIN;
    endfunction

    function automatic coord_t random_pivot();
        case ($urandom_range(5))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return coord_t'($urandom_range(4095)) - coord_t'(2048);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] random_angle();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h2000;
            3:       return 16'h1FFF;
            4:       return {2'($urandom_range(3)), 14'b0};
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    // Drop the vertex valid and hold until every owed result has arrived
    task automatic wait_drained();
        vertex_ch.valid <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge clk);
    endtask

    // Write all three registers while the block is empty; optionally follow
    // with a write to the spare index, which must change nothing
    task automatic program_registers(input coord_t px, input coord_t py,
                                     input logic [ANGLE_W-1:0] ang, input bit spare_write);
        logic [REG_IDX_W-1:0]  idx_list  [4];
        logic [CFG_DATA_W-1:0] data_list [4];
        int                    n_writes;
        int                    w;

        idx_list[0]  = REG_PIVOT_X;
        data_list[0] = CFG_DATA_W'(px);
        idx_list[1]  = REG_PIVOT_Y;
        data_list[1] = CFG_DATA_W'(py);
        idx_list[2]  = REG_ANGLE;
        data_list[2] = CFG_DATA_W'(ang);
        idx_list[3]  = REG_SPARE;
        data_list[3] = CFG_DATA_W'($urandom);
        n_writes     = spare_write ? 4 : 3;

        wait_drained();
        for (w = 0; w < n_writes; w++)
        begin
            cfg_ch.valid     <= 1'b1;
            cfg_ch.reg_index <= idx_list[w];
            cfg_ch.wdata     <= data_list[w];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            case (idx_list[w])
                REG_PIVOT_X: model_px    = coord_t'(data_list[w][COORD_WIDTH-1:0]);
                REG_PIVOT_Y: model_py    = coord_t'(data_list[w][COORD_WIDTH-1:0]);
                REG_ANGLE:   model_angle = data_list[w][ANGLE_W-1:0];
                default:     ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Offer one vertex, with random idle cycles ahead of it, and record the
    // owed rotation once the transfer happens
    task automatic send_vertex(input coord_t x, input coord_t y,
                               input bit typed, input rotation_t want);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            vertex_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vertex_ch.valid   <= 1'b1;
        vertex_ch.point_x <= x;
        vertex_ch.point_y <= y;
        @(posedge clk);
        while (!vertex_ch.ready)
            @(posedge clk);
        pending_rotations.push_back(typed ? want : rotate_about_pivot(x, y));
        vertices_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: directed probes first, then random phases, each with its own
    // pivot and angle
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        probe_t    probe;
        coord_t    pivot_x_sel, pivot_y_sel;
        int        r, phase, k, n_items;
        rotation_t none;

        none = '0;
        rst_n             <= 1'b0;
        vertex_ch.valid   <= 1'b0;
        vertex_ch.point_x <= '0;
        vertex_ch.point_y <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.reg_index  <= '0;
        cfg_ch.wdata      <= '0;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the probe table; reprogramme only when the setting changes
        for (r = 0; r < N_PROBES; r++)
        begin
            probe = DIRECTED_PROBES[r];
            if (probe.piv_x != model_px || probe.piv_y != model_py || probe.ang != model_angle)
                program_registers(probe.piv_x, probe.piv_y, probe.ang, r[0]);
            send_vertex(probe.px, probe.py, probe.typed, probe.want);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // First phase returns to the reset-like origin, second to the
            // opposite corners with the largest angle
            if (phase == 0)
                program_registers('0, '0, random_angle(), 1'b1);
            else if (phase == 1)
                program_registers(C_MAX, C_MIN, 16'hFFFF, 1'b0);
            else
            begin
                pivot_x_sel = random_pivot();
                pivot_y_sel = random_pivot();
                program_registers(pivot_x_sel, pivot_y_sel, random_angle(),
                                  ($urandom_range(1) == 1));
            end

            // Stall the receiver for a long stretch while vertices keep coming
            if (phase == 3)
                hold_off_cycles = HOLD_OFF_LEN;
            calm = (phase == 5);

            n_items = $urandom_range(44, 28);
            for (k = 0; k < n_items; k++)
            begin
                // Pause mid-phase until the block has emptied
                if (phase == 7 && k == n_items / 2)
                    wait_drained();
                send_vertex(random_coord(model_px), random_coord(model_py), 1'b0, none);
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (2 * PIPE_LATENCY)
            @(posedge clk);

        $display("Rotated %0d vertices across %0d register settings, including a %0d-cycle",
                 vertices_sent, settings_used, HOLD_OFF_LEN);
        $display("result stall; %0d results checked, %0d of them clipped.",
                 results_seen, clipped_seen);
        if (failures == 0)
            $display("[rotate_point_about_pivot] OK");
        else
            $display("[rotate_point_about_pivot] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, a counted hold-off when asked, and
    // steady readiness during the calm phase
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each result transfer against the oldest owed rotation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        rotation_t got;
        rotation_t want;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.rotated_x = result_ch.rotated_x;
            got.rotated_y = result_ch.rotated_y;
            got.saturated = result_ch.saturated;
            results_seen++;
            if (got.saturated)
                clipped_seen++;
            if (pending_rotations.size() == 0)
            begin
                $error("result with nothing owed: rotated_x %0d rotated_y %0d saturated %0b",
                       got.rotated_x, got.rotated_y, got.saturated);
                failures++;
            end
            else
            begin
                want = pending_rotations.pop_front();
                if (got.rotated_x !== want.rotated_x)
                begin
                    $error("rotated_x: expected %0d, actual %0d",
                           want.rotated_x, got.rotated_x);
                    failures++;
                end
                if (got.rotated_y !== want.rotated_y)
                begin
                    $error("rotated_y: expected %0d, actual %0d",
                           want.rotated_y, got.rotated_y);
                    failures++;
                end
                if (got.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, actual %0b",
                           want.saturated, got.saturated);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no transfer on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (vertex_ch.valid && vertex_ch.ready)
                   || (result_ch.valid && result_ch.ready)
                   || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Stalled for %0d cycles with %0d results still owed",
                     idle_cycles, pending_rotations.size());
            $display("[rotate_point_about_pivot] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
